// ===== rtl/bmur_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmur_pkg
// Shared types and constants for the bus memory and UART responder.
// ----------------------------------------------------------------------------
package bmur_pkg;

    localparam int unsigned MemDepth  = 65536;
    localparam int unsigned MemAddrW  = $clog2(MemDepth);
    localparam int unsigned LimitW    = 17;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 17;

    // Item operation codes.
    localparam logic [1:0] OP_BUS     = 2'd0;
    localparam logic [1:0] OP_RECEIVE = 2'd1;
    localparam logic [1:0] OP_POLL    = 2'd2;
    localparam logic [1:0] OP_PRELOAD = 2'd3;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] CFG_PROTECT_LIMIT = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_UART_BASE     = 2'd1;

    localparam logic [LimitW-1:0] PROTECT_LIMIT_RST = 17'h08000;
    localparam logic [15:0]       UART_BASE_RST     = 16'hE000;

    // UART status bits: bit 1 transmit empty, bit 0 receive full.
    localparam logic [1:0] STATUS_RST = 2'b10;
    localparam int unsigned ST_RX_FULL  = 0;
    localparam int unsigned ST_TX_EMPTY = 1;

    typedef struct packed {
        logic [1:0]  op;
        logic [29:0] bus_word;
        logic [7:0]  host_byte;
        logic [15:0] load_address;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       host_accepted;
    } t_out_item;

    typedef struct packed {
        logic                re;
        logic                we;
        logic [MemAddrW-1:0] addr;
        logic [7:0]          wdata;
    } t_mem_req;

endpackage : bmur_pkg
`default_nettype wire

// ===== rtl/bmur_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmur_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module bmur_ram #(
    parameter int unsigned ADDR_W = 16,
    parameter int unsigned DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_re,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : bmur_ram
`default_nettype wire

// ===== rtl/bmur_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmur_ctrl
// Bus decode, UART registers, memory request and the output register.
// ----------------------------------------------------------------------------
module bmur_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [bmur_pkg::LimitW-1:0] i_protect_limit,
    input  wire logic [15:0]                 i_uart_base,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire bmur_pkg::t_in_item          i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output bmur_pkg::t_out_item              o_out_item,
    output bmur_pkg::t_mem_req               o_mem_req,
    input  wire logic [7:0]                  i_mem_rdata
);
    import bmur_pkg::*;

    logic [1:0]      r_status, n_status;
    logic [7:0]      r_rx_hold, n_rx_hold;
    logic [7:0]      r_tx_hold, n_tx_hold;
    logic            r_out_valid;
    logic            r_use_mem;
    t_out_item       r_out, n_out;
    logic            n_use_mem;
    logic            accept;
    logic [15:0]     bus_addr;
    logic [15:0]     stat_addr;
    logic            is_io;
    logic            is_write;
    logic [7:0]      dbus;
    logic            above_limit;
    t_mem_req        mem_req;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign bus_addr    = {i_in_item.bus_word[29:27], i_in_item.bus_word[20:8]};
    assign is_io       = i_in_item.bus_word[23];
    assign is_write    = !i_in_item.bus_word[22];
    assign dbus        = i_in_item.bus_word[7:0];
    assign stat_addr   = i_uart_base + 16'd1;
    assign above_limit = {1'b0, bus_addr} >= i_protect_limit;

    always_comb begin
        n_status      = r_status;
        n_rx_hold     = r_rx_hold;
        n_tx_hold     = r_tx_hold;
        n_out         = '0;
        n_use_mem     = 1'b0;
        mem_req       = '0;
        mem_req.addr  = bus_addr;
        mem_req.wdata = dbus;
        unique case (i_in_item.op)
            OP_BUS: begin
                if (!is_io) begin
                    if (is_write) begin
                        if (bus_addr == i_uart_base) begin
                            n_tx_hold             = dbus;
                            n_status[ST_TX_EMPTY] = 1'b0;
                        end else if (above_limit) begin
                            mem_req.we = 1'b1;
                        end
                    end else begin
                        n_out.read_valid = 1'b1;
                        if (bus_addr == stat_addr) begin
                            n_out.read_data = {6'd0, r_status};
                        end else if (bus_addr == i_uart_base) begin
                            n_out.read_data      = r_rx_hold;
                            n_status[ST_RX_FULL] = 1'b0;
                        end else begin
                            mem_req.re = 1'b1;
                            n_use_mem  = 1'b1;
                        end
                    end
                end else if (!is_write) begin
                    n_out.read_valid = 1'b1;
                    n_out.read_data  = dbus;
                end
            end
            OP_RECEIVE: begin
                if (!r_status[ST_RX_FULL]) begin
                    n_rx_hold            = i_in_item.host_byte;
                    n_status[ST_RX_FULL] = 1'b1;
                    n_out.host_accepted  = 1'b1;
                end
            end
            OP_POLL: begin
                if (!r_status[ST_TX_EMPTY]) begin
                    n_out.tx_byte         = r_tx_hold;
                    n_out.tx_valid        = 1'b1;
                    n_status[ST_TX_EMPTY] = 1'b1;
                end
            end
            OP_PRELOAD: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = i_in_item.load_address;
                mem_req.wdata = i_in_item.host_byte;
            end
            default: begin
            end
        endcase
        // Nothing reaches the memory unless the item is actually taken.
        mem_req.re = mem_req.re && accept;
        mem_req.we = mem_req.we && accept;
    end

    assign o_mem_req = mem_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= STATUS_RST;
            r_rx_hold   <= '0;
            r_tx_hold   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_status  <= n_status;
                r_rx_hold <= n_rx_hold;
                r_tx_hold <= n_tx_hold;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out     <= n_out;
            r_use_mem <= n_use_mem;
        end
    end

    // The RAM output register only changes on an accepted read, so it holds
    // while the result item is stalled.
    always_comb begin
        o_out_item = r_out;
        if (r_use_mem) begin
            o_out_item.read_data = i_mem_rdata;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule : bmur_ctrl
`default_nettype wire

// ===== rtl/bus_memory_uart_responder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bus_memory_uart_responder_core
// Serves CPU bus cycles from a 64 KiB memory with a memory-mapped UART.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one item per bus cycle or host action (receive
//   byte, transmit poll, memory preload). Every item yields exactly one
//   result item on the output channel, in order.
//   The result is registered with the RAM read data, so it is valid in the
//   cycle after its item is taken. Items can be taken every cycle while
//   the output keeps up: one item per cycle, set by the single RAM port.
//   If the receiver stalls, the result holds in the output register and the
//   input ready drops until that result is taken.
//   The configuration channel is always ready; writes take effect at once
//   and are meant to be issued only while the block is idle.
//   Reset restores the protect limit and UART base, empties the UART
//   (transmit empty, nothing received) and drops the output valid. The
//   memory is not cleared; its content is undefined until written.
// ----------------------------------------------------------------------------
module bus_memory_uart_responder_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire bmur_pkg::t_in_item             i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output bmur_pkg::t_out_item                 o_out_item,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bmur_pkg::CfgIndexW-1:0] i_cfg_index,
    input  wire logic [bmur_pkg::CfgDataW-1:0]  i_cfg_data
);
    import bmur_pkg::*;

    logic [LimitW-1:0] r_protect_limit;
    logic [15:0]       r_uart_base;
    t_mem_req          mem_req;
    logic [7:0]        mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protect_limit <= PROTECT_LIMIT_RST;
            r_uart_base     <= UART_BASE_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PROTECT_LIMIT) begin
                r_protect_limit <= i_cfg_data[LimitW-1:0];
            end else if (i_cfg_index == CFG_UART_BASE) begin
                r_uart_base <= i_cfg_data[15:0];
            end
        end
    end

    bmur_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_protect_limit (r_protect_limit),
        .i_uart_base     (r_uart_base),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_item       (i_in_item),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_item      (o_out_item),
        .o_mem_req       (mem_req),
        .i_mem_rdata     (mem_rdata)
    );

    bmur_ram #(
        .ADDR_W (MemAddrW),
        .DATA_W (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_re    (mem_req.re),
        .i_we    (mem_req.we),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (mem_rdata)
    );

    // A single item never both reads and writes the memory.
    a_mem_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.re && mem_req.we))
        else $error("memory read and write requested together");

    // Memory is only touched for an item that is taken this cycle.
    a_mem_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.re || mem_req.we) |-> (i_in_valid && o_in_ready))
        else $error("memory access without an accepted item");

    // A result item reports at most one kind of event.
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_out_item.read_valid, o_out_item.tx_valid,
                                  o_out_item.host_accepted}))
        else $error("result item reports more than one event");

    // No result is pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule : bus_memory_uart_responder_core
`default_nettype wire
